>>> src/qabm_pkg.sv
`default_nettype none

package qabm_pkg;

  // Input function codes.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_CHAR  = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  // Result outcome codes.
  localparam logic [2:0] OUT_FOUND     = 3'd0;
  localparam logic [2:0] OUT_MISMATCH  = 3'd1;
  localparam logic [2:0] OUT_FULL      = 3'd2;
  localparam logic [2:0] OUT_EXHAUSTED = 3'd3;
  localparam logic [2:0] OUT_NOTCLOSER = 3'd4;

  // Bracket kind codes, shared by closers and openers; zero means none.
  localparam logic [1:0] BRK_NONE  = 2'd0;
  localparam logic [1:0] BRK_PAREN = 2'd1;
  localparam logic [1:0] BRK_SQUARE = 2'd2;
  localparam logic [1:0] BRK_CURLY = 2'd3;

  // Quote kind codes.
  localparam logic [1:0] QT_NONE   = 2'd0;
  localparam logic [1:0] QT_SINGLE = 2'd1;
  localparam logic [1:0] QT_DOUBLE = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_value;
    logic [15:0] char_pos;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [15:0] match_pos;
  } out_word_t;

  // A character after classification by the front end.
  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  closer;
    logic [1:0]  opener;
    logic [1:0]  quote;
    logic        bslash;
    logic [15:0] pos;
  } cls_word_t;

  // Status of the execution side, watched by checks at the top level.
  typedef struct packed {
    logic searching;
    logic count_zero;
    logic count_over;
    logic result_load;
  } back_stat_t;

endpackage

`default_nettype wire

>>> src/qabm_ram.sv
`default_nettype none

module qabm_ram #(
  parameter int Width = 2,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/qabm_front.sv
`default_nettype none

module qabm_front (
  input  wire logic                 in_valid_i,
  input  wire qabm_pkg::in_word_t   in_data_i,
  output logic                      in_stall_o,
  input  wire logic                 q_full_i,
  output logic                      q_push_o,
  output qabm_pkg::cls_word_t       q_data_o
);

  logic func_known;

  // Function code three is taken off the channel but never queued.
  assign func_known = (in_data_i.func == qabm_pkg::FUNC_START) ||
                      (in_data_i.func == qabm_pkg::FUNC_CHAR) ||
                      (in_data_i.func == qabm_pkg::FUNC_END);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && func_known;

  always_comb begin
    q_data_o.func   = in_data_i.func;
    q_data_o.pos    = in_data_i.char_pos;
    q_data_o.bslash = (in_data_i.char_value == qabm_pkg::CH_BSLASH);

    unique case (in_data_i.char_value)
      qabm_pkg::CH_RPAREN:  q_data_o.closer = qabm_pkg::BRK_PAREN;
      qabm_pkg::CH_RSQUARE: q_data_o.closer = qabm_pkg::BRK_SQUARE;
      qabm_pkg::CH_RCURLY:  q_data_o.closer = qabm_pkg::BRK_CURLY;
      default:              q_data_o.closer = qabm_pkg::BRK_NONE;
    endcase

    unique case (in_data_i.char_value)
      qabm_pkg::CH_LPAREN:  q_data_o.opener = qabm_pkg::BRK_PAREN;
      qabm_pkg::CH_LSQUARE: q_data_o.opener = qabm_pkg::BRK_SQUARE;
      qabm_pkg::CH_LCURLY:  q_data_o.opener = qabm_pkg::BRK_CURLY;
      default:              q_data_o.opener = qabm_pkg::BRK_NONE;
    endcase

    unique case (in_data_i.char_value)
      qabm_pkg::CH_SQUOTE: q_data_o.quote = qabm_pkg::QT_SINGLE;
      qabm_pkg::CH_DQUOTE: q_data_o.quote = qabm_pkg::QT_DOUBLE;
      default:             q_data_o.quote = qabm_pkg::QT_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> src/qabm_queue.sv
`default_nettype none

module qabm_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire qabm_pkg::cls_word_t push_data_i,
  output logic                     full_o,
  output logic                     valid_o,
  output qabm_pkg::cls_word_t      pop_data_o,
  input  wire logic                pop_i
);

  localparam int Depth = 2;

  qabm_pkg::cls_word_t slot_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o     = (cnt_q == 2'(Depth));
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> src/qabm_back.sv
`default_nettype none

module qabm_back #(
  parameter int StackDepth = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire qabm_pkg::cls_word_t q_data_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  output qabm_pkg::out_word_t      out_data_o,
  input  wire logic                out_stall_i,
  output qabm_pkg::back_stat_t     stat_o
);

  localparam int CntW  = $clog2(StackDepth + 1);
  localparam int AddrW = $clog2(StackDepth);

  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      top_q, top_d;
  logic [1:0]      below_q, below_d;
  logic            below_reg_q, below_reg_d;
  logic [1:0]      quote_q, quote_d;
  logic [1:0]      prev_quote_q, prev_quote_d;
  logic            searching_q, searching_d;
  logic            out_valid_q, out_valid_d;
  qabm_pkg::out_word_t out_data_q;

  logic            fire, push, pop, res_load;
  logic [2:0]      res_outcome;
  logic [1:0]      cur_below, ram_rdata;
  logic [CntW-1:0] cnt_m1, cnt_m2;

  assign fire    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = fire;

  // The entry just below the top is either a copy taken on the last push
  // or the read of the stack memory issued on the last pop.
  assign cur_below = below_reg_q ? below_q : ram_rdata;

  always_comb begin
    count_d      = count_q;
    top_d        = top_q;
    quote_d      = quote_q;
    prev_quote_d = prev_quote_q;
    searching_d  = searching_q;
    push         = 1'b0;
    pop          = 1'b0;
    res_load     = 1'b0;
    res_outcome  = qabm_pkg::OUT_FOUND;

    if (fire) begin
      unique case (q_data_i.func)
        qabm_pkg::FUNC_START: begin
          if (q_data_i.closer == qabm_pkg::BRK_NONE) begin
            res_load    = 1'b1;
            res_outcome = qabm_pkg::OUT_NOTCLOSER;
            searching_d = 1'b0;
          end else begin
            top_d        = q_data_i.closer;
            count_d      = CntW'(1);
            quote_d      = qabm_pkg::QT_NONE;
            prev_quote_d = qabm_pkg::QT_NONE;
            searching_d  = 1'b1;
          end
        end
        qabm_pkg::FUNC_END: begin
          if (searching_q) begin
            res_load    = 1'b1;
            res_outcome = qabm_pkg::OUT_EXHAUSTED;
            searching_d = 1'b0;
          end
        end
        qabm_pkg::FUNC_CHAR: begin
          if (searching_q) begin
            prev_quote_d = q_data_i.quote;
            if (quote_q != qabm_pkg::QT_NONE) begin
              if ((q_data_i.quote == quote_q) ||
                  ((prev_quote_q == quote_q) && q_data_i.bslash)) begin
                quote_d = qabm_pkg::QT_NONE;
              end
            end else if (q_data_i.closer != qabm_pkg::BRK_NONE) begin
              if (count_q == CntW'(StackDepth)) begin
                res_load    = 1'b1;
                res_outcome = qabm_pkg::OUT_FULL;
                searching_d = 1'b0;
              end else begin
                push    = 1'b1;
                top_d   = q_data_i.closer;
                count_d = count_q + CntW'(1);
              end
            end else if (q_data_i.opener != qabm_pkg::BRK_NONE) begin
              if (count_q == '0) begin
                res_load    = 1'b1;
                res_outcome = qabm_pkg::OUT_MISMATCH;
                searching_d = 1'b0;
              end else begin
                pop     = 1'b1;
                top_d   = cur_below;
                count_d = count_q - CntW'(1);
                if (top_q != q_data_i.opener) begin
                  res_load    = 1'b1;
                  res_outcome = qabm_pkg::OUT_MISMATCH;
                  searching_d = 1'b0;
                end else if (count_q == CntW'(1)) begin
                  res_load    = 1'b1;
                  res_outcome = qabm_pkg::OUT_FOUND;
                  searching_d = 1'b0;
                end
              end
            end else if (q_data_i.quote != qabm_pkg::QT_NONE) begin
              quote_d = q_data_i.quote;
            end else if (q_data_i.bslash && (prev_quote_q != qabm_pkg::QT_NONE)) begin
              quote_d = prev_quote_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    below_d     = below_q;
    below_reg_d = below_reg_q;
    if (push) begin
      below_d     = top_q;
      below_reg_d = 1'b1;
    end else if (pop) begin
      below_reg_d = 1'b0;
    end
  end

  assign out_valid_d = res_load ? 1'b1 : (out_valid_q && out_stall_i);

  // The memory holds every entry but the top one; the read port always
  // looks at the slot that will sit just below the next top.
  assign cnt_m1 = count_q - CntW'(1);
  assign cnt_m2 = count_d - CntW'(2);

  qabm_ram #(
    .Width (2),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (cnt_m1[AddrW-1:0]),
    .wdata_i (top_q),
    .raddr_i (cnt_m2[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    below_q <= below_d;
    if (res_load) begin
      out_data_q.outcome   <= res_outcome;
      out_data_q.match_pos <= q_data_i.pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      below_reg_q  <= 1'b0;
      quote_q      <= qabm_pkg::QT_NONE;
      prev_quote_q <= qabm_pkg::QT_NONE;
      searching_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      below_reg_q  <= below_reg_d;
      quote_q      <= quote_d;
      prev_quote_q <= prev_quote_d;
      searching_q  <= searching_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign stat_o.searching   = searching_q;
  assign stat_o.count_zero  = (count_q == '0);
  assign stat_o.count_over  = (count_q > CntW'(StackDepth));
  assign stat_o.result_load = res_load;

endmodule

`default_nettype wire

>>> src/quote_aware_brace_matcher.sv
`default_nettype none

// Quote-aware brace matcher. Feed the text backward, one word per character:
// a start word carries the closing brace, character words follow, and an
// end word marks that no text is left. The block answers with at most one
// result word per search: found, mismatch, stack full, text exhausted or not
// a closer, together with the position tag of the character that ended it.
// Text between single or double quotes is skipped, and a backslash next to a
// quote escapes it. Character and end words that arrive while no search runs
// are taken and dropped, as is any word with function code three. The block
// sustains one word per clock cycle while the result output is not stalled.
// The word that causes a result is held in the two-entry queue between the
// classifying front end and the execution side, and the result is then held
// in the result register. The stack lives in a memory of StackDepth two-bit
// entries with the top entry and the one below it held in registers, which
// is what lets a pop follow a pop in the next cycle. The memory needs no
// clearing after reset, so words are taken from the first cycle on.
module quote_aware_brace_matcher #(
  parameter int StackDepth = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               in_valid_i,
  input  wire qabm_pkg::in_word_t in_data_i,
  output logic                    in_stall_o,

  output logic                    out_valid_o,
  output qabm_pkg::out_word_t     out_data_o,
  input  wire logic               out_stall_i
);

  // Classified characters travel from the front end to the execution side
  // through a short queue, so a stalled result does not stall the input at
  // once.
  qabm_pkg::cls_word_t  fq_push_data;
  qabm_pkg::cls_word_t  fq_pop_data;
  logic                 fq_push;
  logic                 fq_full;
  logic                 fq_valid;
  logic                 fq_pop;
  qabm_pkg::back_stat_t back_stat;

  qabm_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (fq_full),
    .q_push_o   (fq_push),
    .q_data_o   (fq_push_data)
  );

  qabm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fq_push),
    .push_data_i (fq_push_data),
    .full_o      (fq_full),
    .valid_o     (fq_valid),
    .pop_data_o  (fq_pop_data),
    .pop_i       (fq_pop)
  );

  // The execution side keeps the search state and the closer stack, and
  // owns the result register.
  qabm_back #(
    .StackDepth (StackDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (fq_valid),
    .q_data_i    (fq_pop_data),
    .q_pop_o     (fq_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .stat_o      (back_stat)
  );

`ifndef SYNTHESIS
  // A running search always has its own closer on the stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.searching |-> !back_stat.count_zero)
    else $error("search running with an empty stack");

  // The stack never holds more entries than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !back_stat.count_over)
    else $error("stack count beyond its depth");

  // Every result ends the search and shows up on the output next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.result_load |=> !back_stat.searching && out_valid_o)
    else $error("result loaded without ending the search");

  // The execution side only takes a word when the result register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_pop |-> fq_valid && !(out_valid_o && out_stall_i))
    else $error("queue popped while the result register is blocked");
`endif

endmodule

`default_nettype wire
